// ===== rtl/ssht_pkg.sv =====
// Package for the SSH client handshake tracker.
// Holds the action codes, protocol constants and the structs shared by the tracker modules.
// No dependencies.
package ssht_pkg;

    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned ActionWidth = 3;
    localparam int unsigned CountWidth  = 32;

    // Client actions reported per received byte.
    localparam logic [ActionWidth-1:0] ACT_NONE    = 3'd0;
    localparam logic [ActionWidth-1:0] ACT_BANNER  = 3'd1;
    localparam logic [ActionWidth-1:0] ACT_KEXINIT = 3'd2;
    localparam logic [ActionWidth-1:0] ACT_NEWKEYS = 3'd3;
    localparam logic [ActionWidth-1:0] ACT_CLOSE   = 3'd4;

    // SSH message codes and framing constants.
    localparam logic [ByteWidth-1:0]  CODE_KEXINIT = 8'h14;
    localparam logic [ByteWidth-1:0]  CODE_NEWKEYS = 8'h15;
    localparam logic [ByteWidth-1:0]  CHAR_LF      = 8'h0A;
    localparam logic [CountWidth-1:0] LEN_MIN      = 32'd3;

    // A registered byte waiting to be processed.
    typedef struct packed {
        logic                 valid;
        logic [ByteWidth-1:0] data_byte;
    } ssht_step_t;

    // The result of processing one byte.
    typedef struct packed {
        logic [ActionWidth-1:0] action;
        logic                   halted;
    } ssht_result_t;

endpackage

// ===== rtl/ssht_byte_if.sv =====
// Channel interfaces of the SSH client handshake tracker.
// One carries received server bytes, the other carries per-byte results; both use ssht_pkg.
interface ssht_byte_if;
    logic                           valid;
    logic                           ready;
    logic [ssht_pkg::ByteWidth-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface ssht_result_if;
    logic                             valid;
    logic                             ready;
    logic [ssht_pkg::ActionWidth-1:0] action;
    logic                             halted;

    modport source (output valid, output action, output halted, input ready);
    modport sink   (input valid, input action, input halted, output ready);
endinterface

// ===== rtl/ssht_in_stage.sv =====
// Input register of the SSH client handshake tracker.
// Captures one server byte per request; depends on ssht_pkg and ssht_byte_if.
module ssht_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    ssht_byte_if.sink            bytes,
    input  logic                 take,
    output ssht_pkg::ssht_step_t step
);

    logic                                valid_reg;
    logic [ssht_pkg::ByteWidth-1:0]      byte_reg;
    logic                                accept;

    // The register frees up whenever its content moves on.
    assign bytes.ready = !valid_reg || take;
    assign accept      = bytes.valid && bytes.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= bytes.data_byte;
        end
    end

    assign step.valid     = valid_reg;
    assign step.data_byte = byte_reg;

endmodule

// ===== rtl/ssht_core.sv =====
// Handshake state tracker of the SSH client handshake tracker.
// Holds the phase and the packet byte count and works out the action for each byte; uses ssht_pkg.
module ssht_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ssht_pkg::ssht_step_t   step,
    input  logic                   fire,
    output ssht_pkg::ssht_result_t result
);

    typedef enum logic [3:0] {
        PH_IDENT,
        PH_LEN1,
        PH_LEN2,
        PH_LEN3,
        PH_LEN4,
        PH_PADLEN,
        PH_CODE,
        PH_DISCARD,
        PH_NEWKEYS,
        PH_LAST,
        PH_ERROR,
        PH_DONE
    } phase_t;

    phase_t                              phase_reg;
    phase_t                              phase_next;
    logic [ssht_pkg::CountWidth-1:0]     remaining_reg;
    logic [ssht_pkg::CountWidth-1:0]     remaining_next;
    logic [ssht_pkg::CountWidth-1:0]     remaining_dec;
    logic [ssht_pkg::CountWidth-1:0]     length_full;
    logic [ssht_pkg::ActionWidth-1:0]    action;
    logic [ssht_pkg::ByteWidth-1:0]      b;
    logic                                ident_ok;

    assign b             = step.data_byte;
    assign remaining_dec = remaining_reg - {{(ssht_pkg::CountWidth-1){1'b0}}, 1'b1};
    assign length_full   = {remaining_reg[ssht_pkg::CountWidth-1:ssht_pkg::ByteWidth], b};

    // Printable characters and white space are legal in the identification line.
    assign ident_ok = ((b >= 8'h09) && (b <= 8'h0D)) || ((b >= 8'h20) && (b <= 8'h7E));

    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        action         = ssht_pkg::ACT_NONE;
        unique case (phase_reg)
            PH_IDENT:
            begin
                if (!ident_ok)
                begin
                    phase_next = PH_ERROR;
                    action     = ssht_pkg::ACT_CLOSE;
                end
                else if (b == ssht_pkg::CHAR_LF)
                begin
                    remaining_next = '0;
                    phase_next     = PH_LEN1;
                    action         = ssht_pkg::ACT_BANNER;
                end
            end
            PH_LEN1:
            begin
                remaining_next = {b, {(ssht_pkg::CountWidth-ssht_pkg::ByteWidth){1'b0}}};
                phase_next     = PH_LEN2;
            end
            PH_LEN2:
            begin
                remaining_next[23:16] = b;
                phase_next            = PH_LEN3;
            end
            PH_LEN3:
            begin
                remaining_next[15:8] = b;
                phase_next           = PH_LEN4;
            end
            PH_LEN4:
            begin
                remaining_next = length_full;
                if (length_full < ssht_pkg::LEN_MIN)
                begin
                    phase_next = PH_ERROR;
                    action     = ssht_pkg::ACT_CLOSE;
                end
                else
                begin
                    phase_next = PH_PADLEN;
                end
            end
            PH_PADLEN:
            begin
                remaining_next = remaining_dec;
                phase_next     = PH_CODE;
            end
            PH_CODE:
            begin
                remaining_next = remaining_dec;
                if (b == ssht_pkg::CODE_KEXINIT)
                begin
                    action     = ssht_pkg::ACT_KEXINIT;
                    phase_next = PH_DISCARD;
                end
                else if (b == ssht_pkg::CODE_NEWKEYS)
                begin
                    action     = ssht_pkg::ACT_NEWKEYS;
                    phase_next = PH_NEWKEYS;
                end
                else
                begin
                    phase_next = PH_DISCARD;
                end
            end
            PH_DISCARD:
            begin
                remaining_next = remaining_dec;
                if (remaining_dec == '0)
                begin
                    phase_next = PH_LEN1;
                end
            end
            PH_NEWKEYS:
            begin
                remaining_next = remaining_dec;
                if (remaining_dec == '0)
                begin
                    phase_next = PH_LAST;
                end
            end
            PH_LAST:
            begin
                action     = ssht_pkg::ACT_CLOSE;
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDENT;
            remaining_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
        end
    end

    assign result.action = action;
    assign result.halted = (phase_next >= PH_ERROR);

    // Once in error or finished, the phase never changes again.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERROR || phase_reg == PH_DONE) |=> $stable(phase_reg))
        else $error("ssht_core: left a halted phase");

    // While counting off packet bytes, at least one byte is always still owed.
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DISCARD || phase_reg == PH_NEWKEYS) |-> (remaining_reg != '0))
        else $error("ssht_core: empty packet count in a counting phase");

    // A close always goes with a halted result.
    a_close_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.action == ssht_pkg::ACT_CLOSE) |-> result.halted)
        else $error("ssht_core: close without halt");

    // A newline in the identification line starts packet deframing.
    a_banner_to_len: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && phase_reg == PH_IDENT && b == ssht_pkg::CHAR_LF) |=> (phase_reg == PH_LEN1))
        else $error("ssht_core: banner did not start length capture");

endmodule

// ===== rtl/ssht_out_stage.sv =====
// Result register of the SSH client handshake tracker.
// Holds one result until the receiver takes it; depends on ssht_pkg and ssht_result_if.
module ssht_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ssht_pkg::ssht_result_t result,
    input  logic                   load,
    output logic                   space,
    ssht_result_if.source          results
);

    logic                    valid_reg;
    ssht_pkg::ssht_result_t  result_reg;

    // The register can take a new result when empty or being emptied now.
    assign space = !valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign results.valid  = valid_reg;
    assign results.action = result_reg.action;
    assign results.halted = result_reg.halted;

endmodule

// ===== rtl/ssh_client_handshake_tracker_top.sv =====
// Top level of the SSH client handshake tracker.
// Connects the input register, the state tracker and the result register; uses ssht_pkg and
// the channel interfaces in ssht_byte_if.sv.
//
// The block follows the server side of an SSH handshake seen by a client. Each request on the
// server_bytes channel carries one received byte, in stream order. For every byte exactly one
// request leaves on the actions channel: the client action it triggers (none, send banner,
// send key-exchange-init, send new-keys, close) and a halted flag that is set once the
// connection is in error or finished and further bytes are ignored.
//
// A byte is registered on acceptance and processed by the tracker once the result register
// has room, and its result is registered there. The tracker's state updates as that result
// is loaded, so one byte per cycle is sustained while the receiver takes every result.
//
// When the receiver stalls, the result register holds its request and the input register can
// still take one more byte; after that server_bytes.ready drops until results move on.
// Reset puts the tracker in the identification-line phase with a zero packet count and
// empties both registers.
module ssh_client_handshake_tracker_top (
    input  logic          clk,
    input  logic          rst_n,
    ssht_byte_if.sink     server_bytes,
    ssht_result_if.source actions
);

    ssht_pkg::ssht_step_t   step;
    ssht_pkg::ssht_result_t result;
    logic                   space;
    logic                   fire;

    // A byte is processed when it is held and the result register has room for its result.
    assign fire = step.valid && space;

    ssht_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (server_bytes),
        .take  (space),
        .step  (step)
    );

    ssht_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .fire   (fire),
        .result (result)
    );

    ssht_out_stage u_out_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .result  (result),
        .load    (fire),
        .space   (space),
        .results (actions)
    );

endmodule

// ===== verif/ssht_handshake_scoreboard.sv =====
// Scoreboard for the SSH client handshake tracker testbench.
// Predicts the action and halted flag of every accepted server byte and checks each result
// request against it. Depends on ssht_pkg and the channel interfaces in ssht_byte_if.sv.
module ssht_handshake_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    ssht_byte_if        server_bytes,
    ssht_result_if      actions,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned checked,
    output int unsigned kexinit_seen,
    output int unsigned newkeys_seen,
    output int unsigned close_seen
);

    // Bytes allowed on the identification line: white space and printable ASCII.
    localparam logic [ssht_pkg::ByteWidth-1:0] ID_SPACE_LO = 8'h09;
    localparam logic [ssht_pkg::ByteWidth-1:0] ID_SPACE_HI = 8'h0D;
    localparam logic [ssht_pkg::ByteWidth-1:0] ID_PRINT_LO = 8'h20;
    localparam logic [ssht_pkg::ByteWidth-1:0] ID_PRINT_HI = 8'h7E;

    typedef enum logic [3:0] {
        SCAN_ID_LINE      = 4'd0,
        SCAN_LEN_B3       = 4'd1,
        SCAN_LEN_B2       = 4'd2,
        SCAN_LEN_B1       = 4'd3,
        SCAN_LEN_B0       = 4'd4,
        SCAN_PAD_LEN      = 4'd5,
        SCAN_MSG_CODE     = 4'd6,
        SCAN_SKIP_BODY    = 4'd7,
        SCAN_NEWKEYS_BODY = 4'd8,
        SCAN_LAST_BYTE    = 4'd9,
        SCAN_FAILED       = 4'd10,
        SCAN_FINISHED     = 4'd11
    } scan_phase_t;

    localparam logic [ssht_pkg::CountWidth-1:0] PKT_ONE =
        {{(ssht_pkg::CountWidth-1){1'b0}}, 1'b1};

    scan_phase_t                      scan_phase = SCAN_ID_LINE;
    logic [ssht_pkg::CountWidth-1:0]  pkt_left   = '0;
    ssht_pkg::ssht_result_t           expected_actions [$];
    ssht_pkg::ssht_result_t           want;
    int unsigned                      n_fail, n_checked, n_kex, n_newkeys, n_close;

    // Advances the handshake state by one server byte and returns the result it should cause.
    function automatic ssht_pkg::ssht_result_t track_server_byte(
        input logic [ssht_pkg::ByteWidth-1:0] rx);
        ssht_pkg::ssht_result_t res;
        res.action = ssht_pkg::ACT_NONE;
        case (scan_phase)
            SCAN_ID_LINE: begin
                if (!((rx >= ID_SPACE_LO && rx <= ID_SPACE_HI) ||
                      (rx >= ID_PRINT_LO && rx <= ID_PRINT_HI))) begin
                    scan_phase = SCAN_FAILED;
                    res.action = ssht_pkg::ACT_CLOSE;
                end else if (rx == ssht_pkg::CHAR_LF) begin
                    pkt_left   = '0;
                    scan_phase = SCAN_LEN_B3;
                    res.action = ssht_pkg::ACT_BANNER;
                end
            end
            SCAN_LEN_B3: begin
                pkt_left   = {rx, 24'h0};
                scan_phase = SCAN_LEN_B2;
            end
            SCAN_LEN_B2: begin
                pkt_left[23:16] = rx;
                scan_phase      = SCAN_LEN_B1;
            end
            SCAN_LEN_B1: begin
                pkt_left[15:8] = rx;
                scan_phase     = SCAN_LEN_B0;
            end
            SCAN_LEN_B0: begin
                pkt_left[7:0] = rx;
                if (pkt_left < ssht_pkg::LEN_MIN) begin
                    scan_phase = SCAN_FAILED;
                    res.action = ssht_pkg::ACT_CLOSE;
                end else begin
                    scan_phase = SCAN_PAD_LEN;
                end
            end
            SCAN_PAD_LEN: begin
                pkt_left   = pkt_left - PKT_ONE;
                scan_phase = SCAN_MSG_CODE;
            end
            SCAN_MSG_CODE: begin
                pkt_left = pkt_left - PKT_ONE;
                if (rx == ssht_pkg::CODE_KEXINIT) begin
                    res.action = ssht_pkg::ACT_KEXINIT;
                    scan_phase = SCAN_SKIP_BODY;
                end else if (rx == ssht_pkg::CODE_NEWKEYS) begin
                    res.action = ssht_pkg::ACT_NEWKEYS;
                    scan_phase = SCAN_NEWKEYS_BODY;
                end else begin
                    scan_phase = SCAN_SKIP_BODY;
                end
            end
            SCAN_SKIP_BODY: begin
                pkt_left = pkt_left - PKT_ONE;
                if (pkt_left == '0)
                    scan_phase = SCAN_LEN_B3;
            end
            SCAN_NEWKEYS_BODY: begin
                pkt_left = pkt_left - PKT_ONE;
                if (pkt_left == '0)
                    scan_phase = SCAN_LAST_BYTE;
            end
            SCAN_LAST_BYTE: begin
                res.action = ssht_pkg::ACT_CLOSE;
                scan_phase = SCAN_FINISHED;
            end
            default: begin
                // Failed or finished: the byte is ignored.
            end
        endcase
        res.halted = (scan_phase >= SCAN_FAILED);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            scan_phase = SCAN_ID_LINE;
            pkt_left   = '0;
            expected_actions.delete();
            n_fail     = 0;
            n_checked  = 0;
            n_kex      = 0;
            n_newkeys  = 0;
            n_close    = 0;
        end else begin
            // Results leave only after their byte has been registered and processed, so checking
            // before predicting is safe.
            if (actions.valid && actions.ready) begin
                if (expected_actions.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected result: action %0d halted %0b", $time,
                             actions.action, actions.halted);
                end else begin
                    want = expected_actions.pop_front();
                    n_checked++;
                    if (actions.action !== want.action || actions.halted !== want.halted)
                        n_fail++;
                    if (actions.action !== want.action)
                        $display("%0t: action mismatch: expected %0d, actual %0d", $time,
                                 want.action, actions.action);
                    if (actions.halted !== want.halted)
                        $display("%0t: halted mismatch: expected %0b, actual %0b", $time,
                                 want.halted, actions.halted);
                    case (want.action)
                        ssht_pkg::ACT_KEXINIT: n_kex++;
                        ssht_pkg::ACT_NEWKEYS: n_newkeys++;
                        ssht_pkg::ACT_CLOSE:   n_close++;
                        default: ;
                    endcase
                end
            end
            if (server_bytes.valid && server_bytes.ready)
                expected_actions.push_back(track_server_byte(server_bytes.data_byte));
        end
        fail_count   <= n_fail;
        pending      <= expected_actions.size();
        checked      <= n_checked;
        kexinit_seen <= n_kex;
        newkeys_seen <= n_newkeys;
        close_seen   <= n_close;
    end

endmodule

// ===== verif/tb_ssh_client_handshake_tracker_top.sv =====
// Testbench top for the SSH client handshake tracker.
// Generates the server byte stream and result back-pressure, and gives the verdict from
// ssht_handshake_scoreboard.sv; depends on ssht_pkg, the channel interfaces and the RTL.
module tb_ssh_client_handshake_tracker_top;

    typedef logic [ssht_pkg::ByteWidth-1:0] byte_t;

    // The random part stops adding packets once this many bytes have gone in.
    localparam int unsigned RANDOM_BYTES = 2000;
    // A correct run stays well within this, even with every pause at its longest.
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    // Cycles of watching after the last result, to catch anything extra.
    localparam int unsigned DRAIN_CYCLES = 8;
    // Bytes sent after the connection has halted, to show they are ignored.
    localparam int unsigned IGNORED_TAIL = 24;

    // Fixed start of the identification line: "SSH-", then the white space bytes other than
    // newline, and the printable extremes.
    localparam logic [8*10-1:0] ID_PREFIX = {8'h53, 8'h53, 8'h48, 8'h2D, 8'h09,
                                             8'h0B, 8'h0C, 8'h0D, 8'h20, 8'h7E};
    // Two packets of the shortest legal length: a key-exchange-init with all-ones padding
    // length and a zero body byte, then an unknown code (zero) with an all-ones body byte.
    localparam logic [8*14-1:0] SHORTEST_PKTS = {8'h00, 8'h00, 8'h00, 8'h03, 8'hFF,
                                                 ssht_pkg::CODE_KEXINIT, 8'h00,
                                                 8'h00, 8'h00, 8'h00, 8'h03, 8'h00,
                                                 8'h00, 8'hFF};

    // Reset comes only once, and the tracker halts for good on close, so each run follows a
    // single connection. The seed picks how that connection ends.
    typedef enum int unsigned {
        END_NEWKEYS,
        END_SHORT_LENGTH,
        END_BAD_ID_LINE
    } stream_end_t;

    logic clk;
    logic rst_n;

    ssht_byte_if   server_bytes ();
    ssht_result_if actions ();

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;
    int unsigned kexinit_seen;
    int unsigned newkeys_seen;
    int unsigned close_seen;

    int unsigned bytes_sent;
    int unsigned packets_sent;
    int unsigned cycle_count;
    int unsigned stall_cycles;
    bit          src_gaps_on;
    bit          sink_stalls_on;
    stream_end_t stream_end;

    ssh_client_handshake_tracker_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .server_bytes (server_bytes),
        .actions      (actions)
    );

    ssht_handshake_scoreboard u_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .server_bytes (server_bytes),
        .actions      (actions),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked),
        .kexinit_seen (kexinit_seen),
        .newkeys_seen (newkeys_seen),
        .close_seen   (close_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a run that stops making progress ends here as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Most pauses are short; about one in five is long enough to fill both
    // pipeline registers and push back on the sender.
    function automatic int unsigned random_pause_len();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Content bytes for packet bodies and the ignored tail. One in eight is a value that
    // means something elsewhere in the protocol, to show it has no effect here.
    function automatic byte_t random_body_byte();
        if ($urandom_range(0, 7) == 0)
        begin
            case ($urandom_range(0, 4))
                0:       return ssht_pkg::CHAR_LF;
                1:       return ssht_pkg::CODE_KEXINIT;
                2:       return ssht_pkg::CODE_NEWKEYS;
                3:       return 8'h00;
                default: return 8'hFF;
            endcase
        end
        return byte_t'($urandom_range(0, 255));
    endfunction

    // Result back-pressure. While stalls are enabled, ready drops now and then for a random
    // pause; while they are disabled, results leave at full rate.
    always @(posedge clk)
    begin
        if (stall_cycles != 0)
        begin
            stall_cycles  <= stall_cycles - 1;
            actions.ready <= 1'b0;
        end
        else if (sink_stalls_on && $urandom_range(0, 5) == 0)
        begin
            stall_cycles  <= random_pause_len() - 1;
            actions.ready <= 1'b0;
        end
        else
        begin
            actions.ready <= 1'b1;
        end
    end

    // Offers one byte and returns once the request has been taken. Valid stays high into
    // the next byte unless a gap is inserted, so back-to-back bytes run at full rate.
    task automatic send_byte(input byte_t rx);
        int unsigned gap;
        server_bytes.valid     <= 1'b1;
        server_bytes.data_byte <= rx;
        @(posedge clk);
        while (!server_bytes.ready)
            @(posedge clk);
        bytes_sent++;
        gap = 0;
        if (src_gaps_on && $urandom_range(0, 3) == 0)
            gap = random_pause_len();
        if (gap != 0)
        begin
            server_bytes.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Packet length field, most significant byte first.
    task automatic send_length(input logic [ssht_pkg::CountWidth-1:0] pkt_len);
        for (int i = 3; i >= 0; i--)
            send_byte(pkt_len[8*i +: 8]);
    endtask

    // One binary packet: length, padding length, message code and pkt_len - 2 body bytes.
    // Each packet redraws whether either side pauses, so some packets run with no gaps at
    // all while others have pauses landing on every phase of the deframing.
    task automatic send_packet(input logic [ssht_pkg::CountWidth-1:0] pkt_len,
                               input byte_t msg_code);
        src_gaps_on     = ($urandom_range(0, 3) != 0);
        sink_stalls_on <= ($urandom_range(0, 3) != 0);
        send_length(pkt_len);
        send_byte(byte_t'($urandom_range(0, 255)));
        send_byte(msg_code);
        for (int unsigned i = 2; i < pkt_len; i++)
            send_byte(random_body_byte());
        packets_sent++;
    endtask

    initial
    begin
        logic [ssht_pkg::CountWidth-1:0] pkt_len;
        byte_t                           msg_code;
        byte_t                           id_char;
        int unsigned                     filler;

        rst_n                  = 1'b0;
        server_bytes.valid     = 1'b0;
        server_bytes.data_byte = '0;
        actions.ready          = 1'b0;
        src_gaps_on            = 1'b1;
        sink_stalls_on         = 1'b1;

        // Most runs get through the whole handshake; a few end on a short length, and
        // fewer still on a bad identification line, since that case stops everything early.
        case ($urandom_range(0, 9))
            0:       stream_end = END_BAD_ID_LINE;
            1, 2, 3: stream_end = END_SHORT_LENGTH;
            default: stream_end = END_NEWKEYS;
        endcase

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Identification line: the fixed prefix with the edges of the accepted ranges, then
        // random printable or white space bytes. A newline is kept out of the filler since
        // it would end the line.
        for (int i = 9; i >= 0; i--)
            send_byte(ID_PREFIX[8*i +: 8]);
        filler = $urandom_range(0, 60);
        repeat (filler)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                id_char = byte_t'($urandom_range(8'h09, 8'h0C));
                if (id_char == ssht_pkg::CHAR_LF)
                    id_char = 8'h0D;
            end
            else
            begin
                id_char = byte_t'($urandom_range(8'h20, 8'h7E));
            end
            send_byte(id_char);
        end

        if (stream_end == END_BAD_ID_LINE)
        begin
            // A NUL, a low control byte, or anything from DEL upward closes the connection.
            case ($urandom_range(0, 3))
                0:       id_char = 8'h00;
                1:       id_char = byte_t'($urandom_range(8'h01, 8'h08));
                2:       id_char = byte_t'($urandom_range(8'h0E, 8'h1F));
                default: id_char = byte_t'($urandom_range(8'h7F, 8'hFF));
            endcase
            send_byte(id_char);
        end
        else
        begin
            // The newline ends the line and asks for the client banner.
            send_byte(ssht_pkg::CHAR_LF);
            for (int i = 13; i >= 0; i--)
                send_byte(SHORTEST_PKTS[8*i +: 8]);
            packets_sent += 2;

            // Random packets: mostly short, now and then one whose length uses the second
            // length byte. A quarter carry the key-exchange-init code; the rest carry any
            // other code. New-keys is held back, since it ends the connection.
            while (bytes_sent < RANDOM_BYTES)
            begin
                if ($urandom_range(0, 19) == 0)
                    pkt_len = 256 + $urandom_range(0, 300);
                else
                    pkt_len = $urandom_range(3, 30);
                if ($urandom_range(0, 3) == 0)
                    msg_code = ssht_pkg::CODE_KEXINIT;
                else
                    do
                        msg_code = byte_t'($urandom_range(0, 255));
                    while (msg_code == ssht_pkg::CODE_NEWKEYS);
                send_packet(pkt_len, msg_code);
            end

            if (stream_end == END_NEWKEYS)
            begin
                // New-keys, its body counted off, then the byte after it closes.
                send_packet($urandom_range(3, 20), ssht_pkg::CODE_NEWKEYS);
                send_byte(random_body_byte());
            end
            else
            begin
                // A length of 0, 1 or 2 is too short to hold padding length and code.
                send_length($urandom_range(0, 2));
            end
        end

        // The connection is halted now; every further byte must give no action.
        repeat (IGNORED_TAIL)
            send_byte(random_body_byte());
        server_bytes.valid <= 1'b0;

        // Let the last acceptance reach the scoreboard, wait for every result, then keep watching
        // for the drain period for anything that should not come.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Stream of %0d server bytes in %0d packets, connection ending by %s.",
                 bytes_sent, packets_sent, stream_end.name());
        $display("Checked %0d results: %0d kexinit, %0d newkeys, %0d close, %0d failures.",
                 checked, kexinit_seen, newkeys_seen, close_seen, fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
